>>> hw/rtl/fbie_pkg.sv
// Shared constants for the bit field insert/delete engine.
// Stream word layout, operation codes and default store size.
// No dependencies.
package fbie_pkg;

	localparam int FIELD_BYTES_DEF = 16;

	// operation codes carried in s_axis_tuser
	localparam int MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_WR  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RD  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_GET = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SET = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CNT = 3'd4;
	localparam logic [MODE_W-1:0] MODE_INS = 3'd5;
	localparam logic [MODE_W-1:0] MODE_DEL = 3'd6;
	localparam logic [MODE_W-1:0] MODE_EXT = 3'd7;

	localparam int OFF_W   = 7;
	localparam int CNT_W   = 8;
	localparam int SPAN_W  = 5;
	localparam int BIDX_W  = 4;
	localparam int BYTE_W  = 8;
	localparam int RES_W   = 16;
	localparam int EXT_MAX = 16;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;

endpackage

>>> hw/rtl/fbie_ram.sv
// Generic simple RAM: one write port, two read ports, registered reads.
// No dependencies.
module fbie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> hw/rtl/bit_field_insert_delete_engine.sv
// Count walks all span bytes, insert/delete walk (span - offset/8) bytes: one byte per
// cycle through the RAM.
// One word in process; s_axis_tready is high only while idle, so the next word is
// accepted at the earliest in the cycle after the result loads into the output register.
// Reset (arst_n, async) clears control and the per-byte valid flags, so the whole
// store reads as zero at once; no clearing pass.
// Top level; uses fbie_pkg and fbie_ram.
module bit_field_insert_delete_engine #(
	parameter int FIELD_BYTES = fbie_pkg::FIELD_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// bit_offset, bit_count, span_bytes, fill_value, byte_index, byte_data, zero pad
	input  logic [fbie_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// mode
	input  logic [fbie_pkg::MODE_W-1:0]        s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// result_value, status, zero pad
	output logic [fbie_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
	import fbie_pkg::*;

	localparam int AW    = (FIELD_BYTES > 1) ? $clog2(FIELD_BYTES) : 1;
	localparam int SAW   = AW + 7;
	localparam int TOTAL = FIELD_BYTES * 8;
	localparam int CKW   = (($clog2(TOTAL + 1) > 9) ? $clog2(TOTAL + 1) : 9) + 1;
	localparam int ACW   = $clog2(TOTAL + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_FIRST = 3'd2;
	localparam logic [2:0] ST_EXT   = 3'd3;
	localparam logic [2:0] ST_LOOP  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]        state_q;
	logic [MODE_W-1:0] mode_q;
	logic [OFF_W-1:0]  off_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SPAN_W-1:0] span_q;
	logic              fill_q;
	logic [BIDX_W-1:0] bidx_q;
	logic [BYTE_W-1:0] bdata_q;

	logic [RES_W-1:0]  res_q;
	logic              st_q;
	logic [BYTE_W-1:0] keep_q;
	logic [15:0]       win_q;
	logic [AW-1:0]     j_q, jend_q;
	logic              iss_q;
	logic              vld_s1;
	logic [AW-1:0]     j_s1;
	logic [ACW-1:0]    acc_q;
	logic [FIELD_BYTES-1:0] vld_q;
	logic              ok_a_s1, ok_b_s1;

	logic              out_vld_q;
	logic [RES_W-1:0]  out_res_q;
	logic              out_st_q;

	logic              accept;
	logic [3:0]        b0;
	logic [4:0]        q;
	logic [2:0]        r;
	logic [CKW-1:0]    off_w, cnt_w, span_w, lim_w;
	logic              span_bad, bad;
	logic [SAW-1:0]    ra_w, rb_w;
	logic              ok_a, ok_b;
	logic [BYTE_W-1:0] qa, qb, da, db;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [BYTE_W-1:0] wdata;
	logic [BYTE_W-1:0] set_byte, new_byte, ins_sh, del_sh;
	logic [15:0]       src16, ext_w, ext_rev;
	logic [23:0]       ext_win;
	logic [3:0]        pc, ones;
	logic              out_load;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign b0            = off_q[6:3];
	assign q             = cnt_q[7:3];
	assign r             = cnt_q[2:0];
	assign off_w         = CKW'(off_q);
	assign cnt_w         = CKW'(cnt_q);
	assign span_w        = CKW'(span_q);
	assign lim_w         = CKW'(span_q) << 3;

	assign span_bad = (span_q == '0) || (span_w > CKW'(FIELD_BYTES));

	always_comb begin
		case (mode_q)
			MODE_WR, MODE_RD:   bad = CKW'(bidx_q) >= CKW'(FIELD_BYTES);
			MODE_GET, MODE_SET: bad = off_w >= CKW'(TOTAL);
			MODE_CNT:           bad = span_bad;
			MODE_INS, MODE_DEL: bad = span_bad || (cnt_q == '0) || (CKW'(b0) >= span_w);
			default:            bad = (cnt_q == '0) || (cnt_w > CKW'(EXT_MAX))
				|| (off_w + cnt_w > CKW'(TOTAL));
		endcase
	end

	// read address selection
	always_comb begin
		ra_w = '0;
		rb_w = '0;
		case (state_q)
			ST_CHECK: begin
				ra_w = (mode_q == MODE_RD) ? SAW'(bidx_q) : SAW'(b0);
				rb_w = SAW'(b0) + SAW'(1);
			end
			ST_FIRST: begin
				ra_w = SAW'(b0) + SAW'(2);
			end
			ST_LOOP: begin
				case (mode_q)
					MODE_INS: begin
						ra_w = SAW'(j_q) - SAW'(q) - SAW'(1);
						rb_w = SAW'(j_q) - SAW'(q);
					end
					MODE_DEL: begin
						ra_w = SAW'(j_q) + SAW'(q);
						rb_w = SAW'(j_q) + SAW'(q) + SAW'(1);
					end
					default: begin
						ra_w = SAW'(j_q);
						rb_w = SAW'(j_q);
					end
				endcase
			end
			default: begin
				ra_w = '0;
				rb_w = '0;
			end
		endcase
	end

	// negative or past-the-store addresses wrap high and read as zero
	assign ok_a = ra_w < SAW'(FIELD_BYTES);
	assign ok_b = rb_w < SAW'(FIELD_BYTES);

	fbie_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(FIELD_BYTES)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (ra_w[AW-1:0]),
		.rdata_a (qa),
		.raddr_b (rb_w[AW-1:0]),
		.rdata_b (qb)
	);

	// bytes never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_a_s1 <= 1'b0;
			ok_b_s1 <= 1'b0;
		end else begin
			ok_a_s1 <= ok_a ? vld_q[ra_w[AW-1:0]] : 1'b0;
			ok_b_s1 <= ok_b ? vld_q[rb_w[AW-1:0]] : 1'b0;
		end
	end

	assign da = ok_a_s1 ? qa : '0;
	assign db = ok_b_s1 ? qb : '0;

	always_comb begin
		set_byte = da;
		set_byte[off_q[2:0]] = fill_q;
	end

	assign src16  = {db, da};
	assign ins_sh = 8'(src16 >> (4'd8 - {1'b0, r}));
	assign del_sh = 8'(src16 >> r);

	always_comb begin
		logic [CKW-1:0] k;
		new_byte = '0;
		for (int i = 0; i < 8; i++) begin
			k = (CKW'(j_s1) << 3) | CKW'(i);
			if (k < off_w) begin
				new_byte[i] = keep_q[i];
			end else if (mode_q == MODE_INS) begin
				new_byte[i] = (k < off_w + cnt_w) ? fill_q : ins_sh[i];
			end else begin
				new_byte[i] = (k + cnt_w < lim_w) ? del_sh[i] : fill_q;
			end
		end
	end

	always_comb begin
		pc = '0;
		for (int i = 0; i < 8; i++) begin
			pc = pc + 4'(da[i]);
		end
	end
	assign ones = fill_q ? pc : 4'd8 - pc;

	// extract: bit at offset ends up most significant
	assign ext_win = {da, win_q};
	assign ext_w   = 16'(ext_win >> off_q[2:0]);
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			ext_rev[15 - i] = ext_w[i];
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		case (state_q)
			ST_CHECK: begin
				if (!bad && mode_q == MODE_WR) begin
					we    = 1'b1;
					waddr = AW'(bidx_q);
					wdata = bdata_q;
				end
			end
			ST_FIRST: begin
				if (mode_q == MODE_SET) begin
					we    = 1'b1;
					waddr = AW'(b0);
					wdata = set_byte;
				end
			end
			ST_LOOP: begin
				if (vld_s1 && (mode_q == MODE_INS || mode_q == MODE_DEL)) begin
					we    = 1'b1;
					waddr = j_s1;
					wdata = new_byte;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= s_axis_tuser;
			off_q   <= s_axis_tdata[6:0];
			cnt_q   <= s_axis_tdata[14:7];
			span_q  <= s_axis_tdata[19:15];
			fill_q  <= s_axis_tdata[20];
			bidx_q  <= s_axis_tdata[24:21];
			bdata_q <= s_axis_tdata[32:25];
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= j_q;
		if (state_q == ST_FIRST) begin
			keep_q <= da;
			win_q  <= {db, da};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_q   <= '0;
			st_q    <= 1'b0;
			j_q     <= '0;
			jend_q  <= '0;
			iss_q   <= 1'b0;
			vld_s1  <= 1'b0;
			acc_q   <= '0;
		end else begin
			vld_s1 <= (state_q == ST_LOOP) && iss_q;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					res_q <= '0;
					st_q  <= bad;
					if (bad || mode_q == MODE_WR) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_FIRST;
					end
				end
				ST_FIRST: begin
					acc_q <= '0;
					case (mode_q)
						MODE_RD: begin
							res_q   <= RES_W'(da);
							state_q <= ST_DONE;
						end
						MODE_GET: begin
							res_q   <= RES_W'(da[off_q[2:0]]);
							state_q <= ST_DONE;
						end
						MODE_EXT: begin
							state_q <= ST_EXT;
						end
						MODE_CNT: begin
							j_q     <= '0;
							jend_q  <= AW'(span_q - 5'd1);
							iss_q   <= 1'b1;
							state_q <= ST_LOOP;
						end
						MODE_INS: begin
							j_q     <= AW'(span_q - 5'd1);
							jend_q  <= AW'(b0);
							iss_q   <= 1'b1;
							state_q <= ST_LOOP;
						end
						MODE_DEL: begin
							j_q     <= AW'(b0);
							jend_q  <= AW'(span_q - 5'd1);
							iss_q   <= 1'b1;
							state_q <= ST_LOOP;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_EXT: begin
					res_q   <= ext_rev >> (5'(EXT_MAX) - cnt_q[4:0]);
					state_q <= ST_DONE;
				end
				ST_LOOP: begin
					// insert walks down, delete and count walk up
					if (iss_q) begin
						if (j_q == jend_q) begin
							iss_q <= 1'b0;
						end else if (mode_q == MODE_INS) begin
							j_q <= j_q - AW'(1);
						end else begin
							j_q <= j_q + AW'(1);
						end
					end
					if (vld_s1 && mode_q == MODE_CNT) begin
						acc_q <= acc_q + ACW'(ones);
					end
					if (!iss_q && !vld_s1) begin
						if (mode_q == MODE_CNT) begin
							res_q <= RES_W'(acc_q);
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	assign out_load = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_res_q <= res_q;
			out_st_q  <= st_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_TDATA_W'({out_st_q, out_res_q});

endmodule
